// ----- rtl/tlms_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlms_pkg
// Shared types, constants and helpers of the trie substitution unit.
// ----------------------------------------------------------------------------
package tlms_pkg;

  // default sizes
  localparam int unsigned STATE_COUNT_DEF  = 512;
  localparam int unsigned SYMBOL_COUNT_DEF = 128;
  localparam int unsigned KEY_MAX_DEF      = 8;
  localparam int unsigned REPL_MAX_DEF     = 8;
  localparam int unsigned POOL_DEPTH_DEF   = 2048;

  // lookahead depth and its derived widths
  localparam int unsigned LA_DEPTH = 8;
  localparam int unsigned LA_IW    = $clog2(LA_DEPTH);
  localparam int unsigned LA_CW    = $clog2(LA_DEPTH + 1);

  localparam logic [15:0] LIMIT_RESET   = 16'd255;
  localparam logic [7:0]  SYM_FOLD_MASK = 8'h7f;

  typedef enum logic [1:0] {
    FUNC_CLEAR = 2'd0,
    FUNC_KEY   = 2'd1,
    FUNC_REPL  = 2'd2,
    FUNC_TEXT  = 2'd3
  } func_e;

  typedef struct packed {
    logic capture;
    logic clr_step;
    logic tbl_clear;
    logic key_enter;
    logic key_resolve;
    logic repl_apply;
    logic text_enter;
    logic walk_init;
    logic walk_rd;
    logic info_rd_cursor;
    logic walk_step;
    logic emit_init;
    logic emit_char;
    logic consume;
    logic text_end;
    logic flush;
  } cmd_t;

  typedef struct packed {
    logic  clr_last;
    func_e func;
    logic  key_look;
    logic  repl_go;
    logic  text_go;
    logic  la_empty;
    logic  walk_cont;
    logic  walk_stop;
    logic  emit_done;
    logic  emit_hit;
    logic  pend_valid;
    logic  out_free;
  } status_t;

  function automatic logic [7:0] lower_ch(input logic [7:0] c);
    logic [7:0] v;
    v = c;
    if (c >= 8'h41 && c <= 8'h5a) begin
      v = c + 8'h20;
    end
    return v;
  endfunction

endpackage

// ----- rtl/tlms_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlms_ctrl
// Sequencer: clearing sweep, item decode, trie walk and emission steps.
// ----------------------------------------------------------------------------
module tlms_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  tlms_pkg::status_t  st_i,
  output tlms_pkg::cmd_t     cmd_o
);

  typedef enum logic [18:0] {
    ST_CLR     = 19'h00001,
    ST_IDLE    = 19'h00002,
    ST_DECODE  = 19'h00004,
    ST_K_ARC   = 19'h00008,
    ST_K_INFO  = 19'h00010,
    ST_K_CHECK = 19'h00020,
    ST_R_INFO  = 19'h00040,
    ST_R_APPLY = 19'h00080,
    ST_W_INIT  = 19'h00100,
    ST_W_ARC   = 19'h00200,
    ST_W_INFO  = 19'h00400,
    ST_W_CHECK = 19'h00800,
    ST_W_DEC   = 19'h01000,
    ST_E_CHK   = 19'h02000,
    ST_E_RD    = 19'h04000,
    ST_E_SEND  = 19'h08000,
    ST_CONSUME = 19'h10000,
    ST_T_END   = 19'h20000,
    ST_FLUSH   = 19'h40000
  } state_e;

  state_e state_q, state_d;

  assign in_stall_o = (state_q != ST_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_CLR: begin
        cmd_o.clr_step = 1'b1;
        if (st_i.clr_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_DECODE;
        end
      end
      ST_DECODE: begin
        unique case (st_i.func)
          tlms_pkg::FUNC_CLEAR: begin
            cmd_o.tbl_clear = 1'b1;
            state_d         = ST_IDLE;
          end
          tlms_pkg::FUNC_KEY: begin
            cmd_o.key_enter = 1'b1;
            state_d         = st_i.key_look ? ST_K_ARC : ST_IDLE;
          end
          tlms_pkg::FUNC_REPL: begin
            state_d = st_i.repl_go ? ST_R_INFO : ST_IDLE;
          end
          tlms_pkg::FUNC_TEXT: begin
            cmd_o.text_enter = 1'b1;
            state_d          = st_i.text_go ? ST_W_INIT : ST_IDLE;
          end
          default: state_d = ST_IDLE;
        endcase
      end
      ST_K_ARC:   state_d = ST_K_INFO;
      ST_K_INFO:  state_d = ST_K_CHECK;
      ST_K_CHECK: begin
        cmd_o.key_resolve = 1'b1;
        state_d           = ST_IDLE;
      end
      ST_R_INFO: begin
        cmd_o.info_rd_cursor = 1'b1;
        state_d              = ST_R_APPLY;
      end
      ST_R_APPLY: begin
        cmd_o.repl_apply = 1'b1;
        state_d          = ST_IDLE;
      end
      ST_W_INIT: begin
        cmd_o.walk_init = 1'b1;
        state_d         = st_i.la_empty ? ST_T_END : ST_W_ARC;
      end
      ST_W_ARC: begin
        cmd_o.walk_rd = 1'b1;
        state_d       = ST_W_INFO;
      end
      ST_W_INFO: begin
        cmd_o.walk_rd = 1'b1;
        state_d       = ST_W_CHECK;
      end
      ST_W_CHECK: begin
        cmd_o.walk_rd   = 1'b1;
        cmd_o.walk_step = 1'b1;
        state_d         = ST_W_DEC;
      end
      ST_W_DEC: begin
        if (st_i.walk_cont) begin
          state_d = ST_W_ARC;
        end else if (st_i.walk_stop) begin
          state_d = ST_T_END;
        end else begin
          cmd_o.emit_init = 1'b1;
          state_d         = ST_E_CHK;
        end
      end
      ST_E_CHK:  state_d = st_i.emit_done ? ST_CONSUME : ST_E_RD;
      ST_E_RD:   state_d = ST_E_SEND;
      ST_E_SEND: begin
        if (st_i.out_free) begin
          cmd_o.emit_char = 1'b1;
          state_d         = st_i.emit_hit ? ST_FLUSH : ST_E_CHK;
        end
      end
      ST_CONSUME: begin
        cmd_o.consume = 1'b1;
        state_d       = ST_W_INIT;
      end
      ST_T_END: begin
        cmd_o.text_end = 1'b1;
        state_d        = ST_FLUSH;
      end
      ST_FLUSH: begin
        if (!st_i.pend_valid) begin
          state_d = ST_IDLE;
        end else if (st_i.out_free) begin
          cmd_o.flush = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLR;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ----- rtl/tlms_dpath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlms_dpath
// Trie, descriptor and pool memories, lookahead buffer and output register.
// ----------------------------------------------------------------------------
module tlms_dpath #(
  parameter int unsigned STATE_COUNT  = tlms_pkg::STATE_COUNT_DEF,
  parameter int unsigned SYMBOL_COUNT = tlms_pkg::SYMBOL_COUNT_DEF,
  parameter int unsigned KEY_MAX      = tlms_pkg::KEY_MAX_DEF,
  parameter int unsigned REPL_MAX     = tlms_pkg::REPL_MAX_DEF,
  parameter int unsigned POOL_DEPTH   = tlms_pkg::POOL_DEPTH_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  tlms_pkg::cmd_t     cmd_i,
  output tlms_pkg::status_t  st_o,
  input  logic [1:0]         func_i,
  input  logic [7:0]         ch_i,
  input  logic               first_i,
  input  logic               last_i,
  input  logic               cfg_we_i,
  input  logic [15:0]        cfg_wdata_i,
  input  logic               out_stall_i,
  output logic               out_valid_o,
  output logic [7:0]         out_char_o,
  output logic               end_of_message_o,
  output logic               table_error_o
);

  localparam int unsigned SW  = $clog2(STATE_COUNT);
  localparam int unsigned FW  = $clog2(STATE_COUNT + 1);
  localparam int unsigned YW  = $clog2(SYMBOL_COUNT);
  localparam int unsigned AW  = SW + YW;
  localparam int unsigned PW  = $clog2(POOL_DEPTH);
  localparam int unsigned PFW = $clog2(POOL_DEPTH + 1);
  localparam int unsigned KLW = $clog2(KEY_MAX + 1);
  localparam int unsigned RLW = $clog2(REPL_MAX + 1);
  localparam int unsigned CW  = tlms_pkg::LA_CW;
  localparam int unsigned IW  = tlms_pkg::LA_IW;
  localparam int unsigned LD  = tlms_pkg::LA_DEPTH;

  typedef struct packed {
    logic           valid;
    logic [PW-1:0]  off;
    logic [RLW-1:0] len;
  } desc_t;

  typedef struct packed {
    logic [SW-1:0] par;
    logic [YW-1:0] sym;
  } link_t;

  function automatic logic [YW-1:0] to_sym(input logic [7:0] c);
    logic [7:0] v;
    v = (9'(c) < 9'(SYMBOL_COUNT)) ? c : (c & tlms_pkg::SYM_FOLD_MASK);
    return v[YW-1:0];
  endfunction

  // memories
  logic [SW-1:0] arc_mem  [2**AW];
  link_t         link_mem [2**SW];
  desc_t         desc_mem [2**SW];
  logic [7:0]    pool_mem [POOL_DEPTH];

  logic          arc_we, link_we, desc_we, pool_we;
  logic [AW-1:0] arc_waddr, arc_raddr;
  logic [SW-1:0] arc_wdata, arc_rdata;
  logic [SW-1:0] link_waddr, desc_waddr, info_raddr;
  link_t         link_wdata, link_rdata;
  desc_t         desc_wdata, desc_rdata;
  logic [PW-1:0] pool_raddr;
  logic [7:0]    pool_rdata;

  // registers
  logic [15:0]          limit_q;
  tlms_pkg::func_e      func_q, func_d;
  logic [7:0]           ch_q, ch_d;
  logic                 first_q, first_d, last_q, last_d;
  logic [FW-1:0]        free_q, free_d;
  logic [PFW-1:0]       fill_q, fill_d;
  logic [SW-1:0]        cursor_q, cursor_d;
  logic [KLW-1:0]       klen_q, klen_d;
  logic                 dropped_q, dropped_d, open_q, open_d, error_q, error_d;
  logic [7:0]           buf_q [LD];
  logic [7:0]           buf_d [LD];
  logic [CW-1:0]        count_q, count_d;
  logic [15:0]          emitted_q, emitted_d;
  logic [SW-1:0]        s_q, s_d;
  logic [CW-1:0]        wi_q, wi_d, bl_q, bl_d;
  logic                 dead_q, dead_d;
  logic [PW-1:0]        boff_q, boff_d;
  logic [RLW-1:0]       brl_q, brl_d, k_q, k_d;
  logic                 pend_valid_q, pend_valid_d, feom_q, feom_d;
  logic [7:0]           pend_q, pend_d;
  logic                 out_valid_q, out_valid_d;
  logic [7:0]           out_char_q, out_char_d;
  logic                 out_eom_q, out_eom_d, out_err_q, out_err_d;
  logic [AW-1:0]        clr_q, clr_d;

  // combinational helpers
  logic [YW-1:0]  key_sym, walk_sym;
  logic           key_hit, walk_hit, key_over, pool_full;
  logic [KLW-1:0] kl_eff;
  logic           drp_eff;
  logic [15:0]    em_eff;
  logic [CW-1:0]  cnt_eff, cnt_m, amt;
  logic [RLW-1:0] emit_len;
  logic [16:0]    em_inc;
  logic           hit;
  logic [7:0]     emit_c;
  logic [CW:0]    idx;

  assign key_sym   = to_sym(ch_q);
  assign walk_sym  = to_sym(buf_q[wi_q[IW-1:0]]);
  assign key_hit   = (arc_rdata != '0) && (FW'(arc_rdata) < free_q) &&
                     (link_rdata.par == cursor_q) && (link_rdata.sym == key_sym);
  assign walk_hit  = (arc_rdata != '0) && (FW'(arc_rdata) < free_q) &&
                     (link_rdata.par == s_q) && (link_rdata.sym == walk_sym);
  assign kl_eff    = first_q ? '0 : klen_q;
  assign drp_eff   = first_q ? 1'b0 : dropped_q;
  assign key_over  = !drp_eff && (kl_eff >= KLW'(KEY_MAX));
  assign pool_full = (fill_q >= PFW'(POOL_DEPTH));
  assign em_eff    = first_q ? '0 : emitted_q;
  assign cnt_eff   = first_q ? '0 : count_q;
  assign emit_len  = (bl_q != '0) ? brl_q : RLW'(1);
  assign em_inc    = {1'b0, emitted_q} + 17'd1;
  assign hit       = (em_inc >= {1'b0, limit_q});
  assign emit_c    = (bl_q != '0) ? pool_rdata : buf_q[0];
  assign amt       = (bl_q != '0) ? bl_q : CW'(1);

  assign arc_raddr  = cmd_i.walk_rd ? {s_q, walk_sym} : {cursor_q, key_sym};
  assign info_raddr = cmd_i.info_rd_cursor ? cursor_q : arc_rdata;
  assign pool_raddr = PW'(boff_q + PW'(k_q));

  always_comb begin
    func_d       = func_q;
    ch_d         = ch_q;
    first_d      = first_q;
    last_d       = last_q;
    free_d       = free_q;
    fill_d       = fill_q;
    cursor_d     = cursor_q;
    klen_d       = klen_q;
    dropped_d    = dropped_q;
    open_d       = open_q;
    error_d      = error_q;
    buf_d        = buf_q;
    count_d      = count_q;
    emitted_d    = emitted_q;
    s_d          = s_q;
    wi_d         = wi_q;
    bl_d         = bl_q;
    dead_d       = dead_q;
    boff_d       = boff_q;
    brl_d        = brl_q;
    k_d          = k_q;
    pend_valid_d = pend_valid_q;
    pend_d       = pend_q;
    feom_d       = feom_q;
    out_char_d   = out_char_q;
    out_eom_d    = out_eom_q;
    out_err_d    = out_err_q;
    out_valid_d  = out_valid_q && out_stall_i;
    clr_d        = clr_q;
    cnt_m        = cnt_eff;
    idx          = '0;
    arc_we       = 1'b0;
    arc_waddr    = {cursor_q, key_sym};
    arc_wdata    = free_q[SW-1:0];
    link_we      = 1'b0;
    link_waddr   = free_q[SW-1:0];
    link_wdata   = '{par: cursor_q, sym: key_sym};
    desc_we      = 1'b0;
    desc_waddr   = free_q[SW-1:0];
    desc_wdata   = '0;
    pool_we      = 1'b0;

    // sweep the trie and state tables to zero after reset
    if (cmd_i.clr_step) begin
      clr_d      = clr_q + AW'(1);
      arc_we     = 1'b1;
      arc_waddr  = clr_q;
      arc_wdata  = '0;
      link_we    = 1'b1;
      link_waddr = clr_q[AW-1 -: SW];
      link_wdata = '0;
      desc_we    = 1'b1;
      desc_waddr = clr_q[AW-1 -: SW];
    end

    if (cmd_i.capture) begin
      func_d  = tlms_pkg::func_e'(func_i);
      ch_d    = (tlms_pkg::func_e'(func_i) == tlms_pkg::FUNC_REPL) ? ch_i
                                                                    : tlms_pkg::lower_ch(ch_i);
      first_d = first_i;
      last_d  = last_i;
    end

    if (cmd_i.tbl_clear) begin
      free_d    = FW'(1);
      fill_d    = '0;
      cursor_d  = '0;
      klen_d    = '0;
      dropped_d = 1'b0;
      open_d    = 1'b0;
      error_d   = 1'b0;
    end

    if (cmd_i.key_enter) begin
      open_d = 1'b0;
      if (first_q) begin
        cursor_d  = '0;
        klen_d    = '0;
        dropped_d = 1'b0;
      end
      if (key_over) begin
        error_d   = 1'b1;
        dropped_d = 1'b1;
        cursor_d  = '0;
      end
    end

    if (cmd_i.key_resolve) begin
      if (key_hit) begin
        cursor_d = arc_rdata;
        klen_d   = klen_q + KLW'(1);
      end else if (free_q < FW'(STATE_COUNT)) begin
        // grow: new state hangs off the cursor
        arc_we   = 1'b1;
        link_we  = 1'b1;
        desc_we  = 1'b1;
        cursor_d = free_q[SW-1:0];
        free_d   = free_q + FW'(1);
        klen_d   = klen_q + KLW'(1);
      end else begin
        error_d   = 1'b1;
        dropped_d = 1'b1;
        cursor_d  = '0;
      end
    end

    if (cmd_i.repl_apply) begin
      desc_waddr = cursor_q;
      if (first_q && pool_full) begin
        error_d = 1'b1;
        open_d  = 1'b0;
      end else if (first_q) begin
        desc_we    = 1'b1;
        desc_wdata = '{valid: 1'b1, off: fill_q[PW-1:0], len: RLW'(1)};
        pool_we    = 1'b1;
        fill_d     = fill_q + PFW'(1);
        open_d     = 1'b1;
      end else if (open_q) begin
        if (desc_rdata.len >= RLW'(REPL_MAX) || pool_full) begin
          error_d = 1'b1;
        end else begin
          desc_we    = 1'b1;
          desc_wdata = '{valid: 1'b1, off: desc_rdata.off, len: desc_rdata.len + RLW'(1)};
          pool_we    = 1'b1;
          fill_d     = fill_q + PFW'(1);
        end
      end
    end

    if (cmd_i.text_enter) begin
      if (em_eff >= limit_q) begin
        count_d   = '0;
        emitted_d = last_q ? '0 : em_eff;
      end else begin
        emitted_d = em_eff;
        if (cnt_eff >= CW'(LD) || cnt_eff >= CW'(KEY_MAX)) begin
          for (int i = 0; i < LD - 1; i++) begin
            buf_d[i] = buf_q[i+1];
          end
          cnt_m = cnt_eff - CW'(1);
        end
        buf_d[cnt_m[IW-1:0]] = ch_q;
        count_d              = cnt_m + CW'(1);
      end
    end

    if (cmd_i.walk_init) begin
      s_d    = '0;
      wi_d   = '0;
      bl_d   = '0;
      dead_d = 1'b0;
    end

    if (cmd_i.walk_step) begin
      if (!walk_hit) begin
        dead_d = 1'b1;
      end else begin
        s_d  = arc_rdata;
        wi_d = wi_q + CW'(1);
        if (desc_rdata.valid) begin
          bl_d   = wi_q + CW'(1);
          boff_d = desc_rdata.off;
          brl_d  = desc_rdata.len;
        end
      end
    end

    if (cmd_i.emit_init) begin
      k_d = '0;
    end

    if (cmd_i.emit_char) begin
      if (pend_valid_q) begin
        out_valid_d = 1'b1;
        out_char_d  = pend_q;
        out_eom_d   = 1'b0;
        out_err_d   = error_q;
      end
      pend_d       = emit_c;
      pend_valid_d = 1'b1;
      emitted_d    = em_inc[15:0];
      k_d          = k_q + RLW'(1);
      if (hit) begin
        count_d = '0;
        feom_d  = 1'b1;
        if (last_q) emitted_d = '0;
      end
    end

    if (cmd_i.consume) begin
      for (int i = 0; i < LD; i++) begin
        idx = (CW + 1)'(i) + {1'b0, amt};
        if (idx < (CW + 1)'(LD)) begin
          buf_d[i] = buf_q[idx[IW-1:0]];
        end
      end
      count_d = count_q - amt;
    end

    if (cmd_i.text_end) begin
      feom_d = last_q;
      if (last_q) begin
        emitted_d = '0;
        count_d   = '0;
      end
    end

    if (cmd_i.flush) begin
      out_valid_d  = 1'b1;
      out_char_d   = pend_q;
      out_eom_d    = feom_q;
      out_err_d    = error_q;
      pend_valid_d = 1'b0;
    end
  end

  // memory ports
  always_ff @(posedge clk_i) begin
    if (arc_we) arc_mem[arc_waddr] <= arc_wdata;
    arc_rdata <= arc_mem[arc_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (link_we) link_mem[link_waddr] <= link_wdata;
    link_rdata <= link_mem[info_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (desc_we) desc_mem[desc_waddr] <= desc_wdata;
    desc_rdata <= desc_mem[info_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (pool_we) pool_mem[fill_q[PW-1:0]] <= ch_q;
    pool_rdata <= pool_mem[pool_raddr];
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q      <= tlms_pkg::LIMIT_RESET;
      free_q       <= FW'(1);
      fill_q       <= '0;
      cursor_q     <= '0;
      klen_q       <= '0;
      dropped_q    <= 1'b0;
      open_q       <= 1'b0;
      error_q      <= 1'b0;
      count_q      <= '0;
      emitted_q    <= '0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
      clr_q        <= '0;
    end else begin
      if (cfg_we_i) limit_q <= cfg_wdata_i;
      free_q       <= free_d;
      fill_q       <= fill_d;
      cursor_q     <= cursor_d;
      klen_q       <= klen_d;
      dropped_q    <= dropped_d;
      open_q       <= open_d;
      error_q      <= error_d;
      count_q      <= count_d;
      emitted_q    <= emitted_d;
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
      clr_q        <= clr_d;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    func_q     <= func_d;
    ch_q       <= ch_d;
    first_q    <= first_d;
    last_q     <= last_d;
    buf_q      <= buf_d;
    s_q        <= s_d;
    wi_q       <= wi_d;
    bl_q       <= bl_d;
    dead_q     <= dead_d;
    boff_q     <= boff_d;
    brl_q      <= brl_d;
    k_q        <= k_d;
    pend_q     <= pend_d;
    feom_q     <= feom_d;
    out_char_q <= out_char_d;
    out_eom_q  <= out_eom_d;
    out_err_q  <= out_err_d;
  end

  assign st_o.clr_last   = (clr_q == '1);
  assign st_o.func       = func_q;
  assign st_o.key_look   = !drp_eff && !key_over;
  assign st_o.repl_go    = (cursor_q != '0);
  assign st_o.text_go    = (em_eff < limit_q);
  assign st_o.la_empty   = (count_q == '0);
  assign st_o.walk_cont  = !dead_q && (wi_q < count_q);
  assign st_o.walk_stop  = !dead_q && (count_q < CW'(KEY_MAX)) && !last_q;
  assign st_o.emit_done  = (k_q >= emit_len);
  assign st_o.emit_hit   = hit;
  assign st_o.pend_valid = pend_valid_q;
  assign st_o.out_free   = !out_valid_q || !out_stall_i;

  assign out_valid_o      = out_valid_q;
  assign out_char_o       = out_char_q;
  assign end_of_message_o = out_eom_q;
  assign table_error_o    = out_err_q;

endmodule

// ----- rtl/trie_longest_match_substitution_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trie_longest_match_substitution_unit
// Longest-match dictionary substitution over a character trie.
// ----------------------------------------------------------------------------
// After reset the unit sweeps its trie arc memory, and with it the link and
// descriptor tables, to zero, one arc entry a cycle, and holds in_stall_o
// high until that is done; output_limit writes are taken throughout. One
// item is in flight at a time. A clear item is accepted and decoded, a key
// item then adds a trie arc read, a state link read and a resolve step, and
// a replacement item a descriptor read and an update. A text item is
// accepted, decoded, ended and its held last character flushed, around its
// passes over the lookahead: a pass that emits visits trie levels (arc
// memory read, then link and descriptor read, check, decide) and then emits
// characters (check, pool memory read, send), a pass that finds the
// lookahead empty goes straight to the end step, and one that stops to wait
// for more text only visits trie levels; a pass that reaches output_limit
// ends right after its last send. Output stalls hold the send and flush
// steps. Clearing the table is cheap: arcs are checked against the link
// table of their target state, so stale arcs from an older table never
// match. A finished result sits in an output register, so the walk of the
// next pass goes on while it waits to be taken.
// ----------------------------------------------------------------------------
module trie_longest_match_substitution_unit #(
  parameter int unsigned STATE_COUNT  = tlms_pkg::STATE_COUNT_DEF,
  parameter int unsigned SYMBOL_COUNT = tlms_pkg::SYMBOL_COUNT_DEF,
  parameter int unsigned KEY_MAX      = tlms_pkg::KEY_MAX_DEF,
  parameter int unsigned REPL_MAX     = tlms_pkg::REPL_MAX_DEF,
  parameter int unsigned POOL_DEPTH   = tlms_pkg::POOL_DEPTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input transaction
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  func_i,
  input  logic [7:0]  ch_i,
  input  logic        first_i,
  input  logic        last_i,
  // output transaction
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  out_char_o,
  output logic        end_of_message_o,
  output logic        table_error_o,
  // output_limit register
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i
);

  tlms_pkg::cmd_t    cmd;
  tlms_pkg::status_t st;

  // sequence the steps of each item
  tlms_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .st_i       (st),
    .cmd_o      (cmd)
  );

  // hold the trie, pool, lookahead and output register
  tlms_dpath #(
    .STATE_COUNT  (STATE_COUNT),
    .SYMBOL_COUNT (SYMBOL_COUNT),
    .KEY_MAX      (KEY_MAX),
    .REPL_MAX     (REPL_MAX),
    .POOL_DEPTH   (POOL_DEPTH)
  ) u_dpath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .st_o             (st),
    .func_i           (func_i),
    .ch_i             (ch_i),
    .first_i          (first_i),
    .last_i           (last_i),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .out_stall_i      (out_stall_i),
    .out_valid_o      (out_valid_o),
    .out_char_o       (out_char_o),
    .end_of_message_o (end_of_message_o),
    .table_error_o    (table_error_o)
  );

  // an accepted transaction stalls the input in the cycle after it
  a_accept_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken on back-to-back cycles");

  // a character is produced only when the output register can take one
  a_emit_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit_char |-> st.out_free)
    else $error("character produced with output register busy");

  // a flush always moves a held character into a free output register
  a_flush_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.flush |-> st.pend_valid && st.out_free)
    else $error("flush without a held character or output room");

  // the sweep runs only before the first transaction is taken
  a_sweep_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.clr_step |-> in_stall_o)
    else $error("input open during the clearing sweep");

endmodule
